FILE: rtl/qru_pkg.sv
package qru_pkg;

	// default fixed-point format, signed Q16.16
	localparam int QRU_WORD_BITS = 32;
	localparam int QRU_FRAC_BITS = 16;

	// opcodes
	localparam logic [1:0] OP_MUL   = 2'd0;
	localparam logic [1:0] OP_ROT   = 2'd1;
	localparam logic [1:0] OP_XFORM = 2'd2;

	// hamilton product: component c takes p[k] * q[c ^ k], negated where bit k is set
	localparam logic [3:0] QM_NEG [4] = '{4'hE, 4'h8, 4'h2, 4'h4};

endpackage

FILE: rtl/quaternion_rotate_unit.sv
// quaternion multiply / rotate / frame transform, signed fixed point
// pipeline: 6 register stages from the input to out_valid
// throughput: one transaction per cycle while out_stall is low, two chained 3-stage product pipelines
// stages fill independently, so bubbles close up while out_stall is high
// reset: arst_n clears only the stage valid bits, payload registers are not reset
module quaternion_rotate_unit #(
	parameter int FRAC_BITS = qru_pkg::QRU_FRAC_BITS,
	parameter int WORD_BITS = qru_pkg::QRU_WORD_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  op_select,
	input  logic signed [WORD_BITS-1:0] a_w,
	input  logic signed [WORD_BITS-1:0] a_x,
	input  logic signed [WORD_BITS-1:0] a_y,
	input  logic signed [WORD_BITS-1:0] a_z,
	input  logic signed [WORD_BITS-1:0] b_w,
	input  logic signed [WORD_BITS-1:0] b_x,
	input  logic signed [WORD_BITS-1:0] b_y,
	input  logic signed [WORD_BITS-1:0] b_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [WORD_BITS-1:0] res_w,
	output logic signed [WORD_BITS-1:0] res_x,
	output logic signed [WORD_BITS-1:0] res_y,
	output logic signed [WORD_BITS-1:0] res_z,
	output logic                        saturated
);
	import qru_pkg::*;

	localparam int W      = WORD_BITS;
	localparam int QW     = 4 * W;
	localparam int TAG1_W = 2 + QW;
	localparam int TAG2_W = 3 + QW;

	// first product operands
	// multiply:  a * b
	// rotate:    v * conj(a)   (v has zero scalar part)
	// transform: v * a
	logic                 is_mul;
	logic [3:0][W-1:0]    a_q4, b_q4, v_q4;
	logic [3:0][W-1:0]    p1, q1;
	logic                 conj_q1;
	logic [TAG1_W-1:0]    tag1_in, tag1_out;

	logic                 p1_ready, p1_valid;
	logic [3:0][W-1:0]    r1;
	logic                 sat1;

	// second product: a * t for rotate, conj(a) * t for transform
	logic [1:0]           op_p2;
	logic [3:0][W-1:0]    a_p2;
	logic                 conj_p2;
	logic [TAG2_W-1:0]    tag2_in, tag2_out;

	logic                 p2_ready;
	logic [3:0][W-1:0]    r2;
	logic                 sat2;

	// after the second product
	logic [1:0]           op_out;
	logic                 sat1_out;
	logic [3:0][W-1:0]    r1_out;

	assign is_mul  = (op_select == OP_MUL);
	assign a_q4    = {a_z, a_y, a_x, a_w};
	assign b_q4    = {b_z, b_y, b_x, b_w};
	assign v_q4    = {b_z, b_y, b_x, {W{1'b0}}};
	assign p1      = is_mul ? a_q4 : v_q4;
	assign q1      = is_mul ? b_q4 : a_q4;
	assign conj_q1 = (op_select == OP_ROT);
	assign tag1_in = {op_select, a_q4};

	qru_qmul #(
		.W     (W),
		.F     (FRAC_BITS),
		.TAG_W (TAG1_W)
	) u_pass1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (p1_ready),
		.p         (p1),
		.q         (q1),
		.conj_p    (1'b0),
		.conj_q    (conj_q1),
		.tag_in    (tag1_in),
		.out_valid (p1_valid),
		.out_ready (p2_ready),
		.r         (r1),
		.sat       (sat1),
		.tag_out   (tag1_out)
	);

	assign in_stall = !p1_ready;

	assign op_p2   = tag1_out[TAG1_W-1 -: 2];
	assign a_p2    = tag1_out[QW-1:0];
	assign conj_p2 = (op_p2 == OP_XFORM);
	// the first result rides along so the multiply opcode can return it
	assign tag2_in = {op_p2, sat1, r1};

	qru_qmul #(
		.W     (W),
		.F     (FRAC_BITS),
		.TAG_W (TAG2_W)
	) u_pass2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p1_valid),
		.in_ready  (p2_ready),
		.p         (a_p2),
		.q         (r1),
		.conj_p    (conj_p2),
		.conj_q    (1'b0),
		.tag_in    (tag2_in),
		.out_valid (out_valid),
		.out_ready (!out_stall),
		.r         (r2),
		.sat       (sat2),
		.tag_out   (tag2_out)
	);

	assign op_out   = tag2_out[TAG2_W-1 -: 2];
	assign sat1_out = tag2_out[QW];
	assign r1_out   = tag2_out[QW-1:0];

	// result select from the last stage registers, stable while stalled
	// for the vector opcodes a clipped scalar part still raises the flag
	always_comb begin
		case (op_out)
			OP_MUL: begin
				res_w     = r1_out[0];
				res_x     = r1_out[1];
				res_y     = r1_out[2];
				res_z     = r1_out[3];
				saturated = sat1_out;
			end
			OP_ROT, OP_XFORM: begin
				res_w     = '0;
				res_x     = r2[1];
				res_y     = r2[2];
				res_z     = r2[3];
				saturated = sat1_out | sat2;
			end
			default: begin
				res_w     = '0;
				res_x     = '0;
				res_y     = '0;
				res_z     = '0;
				saturated = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/qru_qmul.sv
module qru_qmul #(
	parameter int W     = qru_pkg::QRU_WORD_BITS,
	parameter int F     = qru_pkg::QRU_FRAC_BITS,
	parameter int TAG_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [3:0][W-1:0]    p,
	input  logic [3:0][W-1:0]    q,
	input  logic                 conj_p,
	input  logic                 conj_q,
	input  logic [TAG_W-1:0]     tag_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [3:0][W-1:0]    r,
	output logic                 sat,
	output logic [TAG_W-1:0]     tag_out
);
	import qru_pkg::*;

	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 2;
	localparam logic signed [SW-1:0] HALF = SW'(1) << (F - 1);
	localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	logic signed [PW-1:0] prod_s1 [4][4];
	logic [3:0]           neg_s1 [4];
	logic [TAG_W-1:0]     tag_s1;

	logic signed [SW-1:0] sum_d [4];
	logic signed [SW-1:0] sum_s2 [4];
	logic [TAG_W-1:0]     tag_s2;

	logic [3:0][W-1:0]    res_d;
	logic [3:0]           ovf_d;
	logic [3:0][W-1:0]    res_s3;
	logic                 sat_s3;
	logic [TAG_W-1:0]     tag_s3;

	// a stage takes new data when empty or when the next one moves
	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// stage 1: sixteen full products
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			for (int c = 0; c < 4; c++) begin
				for (int k = 0; k < 4; k++) begin
					prod_s1[c][k] <= $signed(p[k]) * $signed(q[2'(c ^ k)]);
					neg_s1[c][k]  <= QM_NEG[c][k] ^ (conj_p && (k != 0))
						^ (conj_q && ((c ^ k) != 0));
				end
			end
			tag_s1 <= tag_in;
		end
	end

	// stage 2: signed four-term sums
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			sum_d[c] = '0;
			for (int k = 0; k < 4; k++) begin
				if (neg_s1[c][k]) sum_d[c] = sum_d[c] - SW'(prod_s1[c][k]);
				else              sum_d[c] = sum_d[c] + SW'(prod_s1[c][k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			sum_s2 <= sum_d;
			tag_s2 <= tag_s1;
		end
	end

	// stage 3: round half up, drop fraction, clip to word range
	always_comb begin
		logic signed [SW-1:0] rnd;
		logic [SW-F-W:0]      upper;
		for (int c = 0; c < 4; c++) begin
			rnd      = sum_s2[c] + HALF;
			upper    = rnd[SW-1:F+W-1];
			ovf_d[c] = !((&upper) || !(|upper));
			if (!ovf_d[c])        res_d[c] = rnd[F+W-1:F];
			else if (upper[SW-F-W]) res_d[c] = MIN_W;
			else                  res_d[c] = MAX_W;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			res_s3 <= res_d;
			sat_s3 <= |ovf_d;
			tag_s3 <= tag_s2;
		end
	end

	assign out_valid = v_s3;
	assign r         = res_s3;
	assign sat       = sat_s3;
	assign tag_out   = tag_s3;

endmodule
